FILE: sv/itrd_pkg.sv
// Package with shared constants, types and helper functions for the radix digit converter.
package itrd_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;
   localparam int RADIX_BITS         = 6;
   localparam int CHAR_BITS          = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] DECIMAL_TEN = 6'd10;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0] ASCII_A    = 7'd65;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_READ,
      ST_SEND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic read;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;
      logic quo_zero;
      logic cnt_last;
      logic idx_zero;
      logic out_free;
   } status_type;

   function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d < DECIMAL_TEN) begin
         res = ASCII_ZERO + {1'b0, d};
      end else begin
         res = ASCII_A + {1'b0, d} - {1'b0, DECIMAL_TEN};
      end
      return res;
   endfunction

endpackage

FILE: sv/itrd_req_if.sv
// Input channel interface carrying one integer per item.
interface itrd_req_if #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

FILE: sv/itrd_rsp_if.sv
// Result channel interface carrying one ASCII digit per item.
interface itrd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [itrd_pkg::CHAR_BITS-1:0] digit_char;
   logic                           last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: sv/itrd_datapath.sv
// Datapath: radix register, bit-serial divider, digit memory and output register.
module itrd_datapath #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [itrd_pkg::RADIX_BITS-1:0] csr_wdata,
   input  logic [VALUE_BITS-1:0]           value,
   input  itrd_pkg::cmd_type               cmd,
   output itrd_pkg::status_type            status,
   itrd_rsp_if.source                      rsp_chan
);
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int RB    = itrd_pkg::RADIX_BITS;

   logic [RB-1:0]         radix_ff;
   logic [RB-1:0]         radix_eff;
   logic [VALUE_BITS-1:0] quo_ff;
   logic [RB-1:0]         rem_ff;
   logic [CNT_W-1:0]      bit_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [RB-1:0]         mem [VALUE_BITS];
   logic [RB-1:0]         rd_data_ff;

   logic                           out_valid_ff;
   logic [itrd_pkg::CHAR_BITS-1:0] out_char_ff;
   logic                           out_last_ff;

   logic [RB:0]   trial;
   logic          qbit;
   logic [RB-1:0] rem_in;

   assign radix_eff = itrd_pkg::clamp_radix(radix_ff);

   // One restoring division step: bring down the next dividend bit.
   always_comb begin
      trial  = {rem_ff, quo_ff[VALUE_BITS-1]};
      qbit   = (trial >= {1'b0, radix_eff});
      rem_in = qbit ? RB'(trial - {1'b0, radix_eff}) : trial[RB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrd_pkg::RADIX_RESET;
      end else if (csr_we) begin
         radix_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff <= '0;
         rem_ff <= '0;
         bit_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.load) begin
         quo_ff <= value;
         rem_ff <= '0;
         bit_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[VALUE_BITS-2:0], qbit};
         rem_ff <= rem_in;
         bit_ff <= bit_ff + 1'b1;
      end else if (cmd.store) begin
         rem_ff <= '0;
         bit_ff <= '0;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.store) begin
         idx_ff <= cnt_ff;
      end else if (cmd.out_load) begin
         idx_ff <= idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[cnt_ff] <= rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_char_ff <= itrd_pkg::digit_to_ascii(rd_data_ff);
         out_last_ff <= (idx_ff == '0);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.digit_char = out_char_ff;
   assign rsp_chan.last_digit = out_last_ff;

   assign status.div_last = (bit_ff == CNT_W'(VALUE_BITS - 1));
   assign status.quo_zero = (quo_ff == '0);
   assign status.cnt_last = (cnt_ff == CNT_W'(VALUE_BITS - 1));
   assign status.idx_zero = (idx_ff == '0);
   assign status.out_free = !out_valid_ff || rsp_chan.ready;
endmodule

FILE: sv/itrd_controller.sv
// Controller state machine sequencing division, digit storage and readout.
module itrd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  itrd_pkg::status_type status,
   output itrd_pkg::cmd_type    cmd
);
   itrd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = itrd_pkg::ST_DIV;
            end
         end
         itrd_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = itrd_pkg::ST_STORE;
            end
         end
         itrd_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            // Stop once the quotient is exhausted or the buffer is full.
            if (status.quo_zero || status.cnt_last) begin
               state_in = itrd_pkg::ST_READ;
            end else begin
               state_in = itrd_pkg::ST_DIV;
            end
         end
         itrd_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = itrd_pkg::ST_SEND;
         end
         itrd_pkg::ST_SEND: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = status.idx_zero ? itrd_pkg::ST_IDLE : itrd_pkg::ST_READ;
            end
         end
         default: begin
            state_in = itrd_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

FILE: sv/integer_to_radix_digits.sv
// Top level of the integer to radix digit converter.
//
//   channel   direction  payload                      handshake
//   req_chan  in         value[VALUE_BITS-1:0]        valid / ready
//   rsp_chan  out        digit_char[6:0], last_digit  valid / ready
//   csr       in         csr_wdata[5:0] (radix)       csr_we, no wait
//
// Each digit is found by the bit-serial divider, one quotient bit per division step,
// and is then stored; the readout fetches each digit from the registered digit memory
// and then loads it into the output register.
// Reset is synchronous and restores radix ten. A stalled result channel holds
// the readout; a new item is taken once the last digit is in the output register.
module integer_to_radix_digits #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   itrd_req_if.sink                        req_chan,
   itrd_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [itrd_pkg::RADIX_BITS-1:0] csr_wdata
);
   itrd_pkg::cmd_type    cmd;
   itrd_pkg::status_type status;

   itrd_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   itrd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .value     (req_chan.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_chan  (rsp_chan)
   );
endmodule
